### hw/rtl/pwhc_pkg.sv
// Shared types, codes and helpers of the pilot-wire heating controller.
package pwhc_pkg;

   // Fixed field layout: four setpoint fields and four wire bits
   localparam int unsigned FIELD_ZONES = 4;
   localparam int unsigned MODE_W      = 3;
   localparam int unsigned SEC_W       = 9;
   localparam int unsigned FROST_W     = 8;
   localparam int unsigned CSR_ADDR_W  = 5;
   localparam int unsigned CSR_DATA_W  = 32;

   // Event codes
   localparam logic [1:0] OP_MAINS_EDGE  = 2'd0;
   localparam logic [1:0] OP_HALF_PERIOD = 2'd1;
   localparam logic [1:0] OP_TRIAC_CUT   = 2'd2;
   localparam logic [1:0] OP_SECOND_TICK = 2'd3;

   // Setpoint / mode codes
   localparam logic [MODE_W-1:0] MODE_OFF           = 3'd0;
   localparam logic [MODE_W-1:0] MODE_COMFORT       = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ECO           = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ECO_PLUS      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ECO_PLUS_PLUS = 3'd4;
   localparam logic [MODE_W-1:0] MODE_FROST         = 3'd5;

   // Register indexes (word address)
   localparam logic [2:0] REG_HW_VERSION   = 3'd0;
   localparam logic [2:0] REG_FROST_HALFW  = 3'd1;
   localparam logic [2:0] REG_ECO_ON       = 3'd2;
   localparam logic [2:0] REG_ECO_PLUS_ON  = 3'd3;
   localparam logic [2:0] REG_CADENCE      = 3'd4;

   typedef struct packed {
      logic [1:0]        operation;
      logic [MODE_W-1:0] setpoint_zone0;
      logic [MODE_W-1:0] setpoint_zone1;
      logic [MODE_W-1:0] setpoint_zone2;
      logic [MODE_W-1:0] setpoint_zone3;
   } req_type;

   typedef struct packed {
      logic [FIELD_ZONES-1:0] wire_levels;
      logic                   mains_lost;
      logic                   edge_ignored;
   } rsp_type;

   // Per-event controls and configuration handed to every zone
   typedef struct packed {
      logic               drive;
      logic               positive;
      logic               cut;
      logic               tick;
      logic               hw_direct;
      logic [FROST_W-1:0] frost_halfwaves;
      logic [SEC_W-1:0]   eco_on;
      logic [SEC_W-1:0]   eco_plus_on;
      logic [SEC_W-1:0]   period;
   } zone_ctl_type;

   function automatic logic mode_is_eco(input logic [MODE_W-1:0] m);
      return (m == MODE_ECO) || (m == MODE_ECO_PLUS);
   endfunction

endpackage

### hw/rtl/pwhc_zone.sv
// One heating zone: setpoint tracking, forced frost, eco cadence and wire level.
module pwhc_zone
   import pwhc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  zone_ctl_type        ctl,
   input  logic [MODE_W-1:0]   setpoint,
   input  logic                wire_cur,
   output logic                wire_next
);

   logic [MODE_W-1:0]  applied_ff, applied_in;
   logic [MODE_W-1:0]  prev_ff, prev_in;
   logic [FROST_W-1:0] frost_cnt_ff, frost_cnt_in;
   logic               restart_ff, restart_in;
   logic [SEC_W-1:0]   sec_ff, sec_in;
   logic               eco_ff, eco_in;
   logic               eco_plus_ff, eco_plus_in;

   // Event logic for this zone
   always_comb begin
      logic [MODE_W-1:0]  mode_sel;
      logic [FROST_W-1:0] cnt;
      logic               forced;
      logic               lvl;
      logic [SEC_W-1:0]   c;
      logic [SEC_W:0]     c_inc;

      applied_in   = applied_ff;
      prev_in      = prev_ff;
      frost_cnt_in = frost_cnt_ff;
      restart_in   = restart_ff;
      sec_in       = sec_ff;
      eco_in       = eco_ff;
      eco_plus_in  = eco_plus_ff;
      wire_next    = wire_cur;

      // setpoint change tracking and forced frost
      cnt      = frost_cnt_ff;
      mode_sel = setpoint;
      forced   = 1'b0;
      if (setpoint != prev_ff) begin
         if (mode_is_eco(setpoint)) begin
            if (ctl.drive) restart_in = 1'b1;
            if (mode_is_eco(prev_ff) || prev_ff == MODE_ECO_PLUS_PLUS)
               cnt = ctl.frost_halfwaves;
         end
         if (setpoint == MODE_COMFORT && mode_is_eco(prev_ff))
            cnt = ctl.frost_halfwaves;
      end
      if (cnt != '0) begin
         cnt      = cnt - FROST_W'(1);
         mode_sel = MODE_FROST;
         forced   = 1'b1;
      end

      // half-wave level for the selected mode
      case (mode_sel)
         MODE_OFF:           lvl = ctl.positive;
         MODE_ECO:           lvl = eco_ff;
         MODE_ECO_PLUS:      lvl = eco_plus_ff;
         MODE_ECO_PLUS_PLUS: lvl = 1'b1;
         MODE_FROST:         lvl = !ctl.positive;
         default:            lvl = 1'b0;
      endcase
      lvl = lvl ^ !ctl.hw_direct;

      // cadence counter step
      c     = restart_ff ? '0 : sec_ff;
      c_inc = {1'b0, c} + (SEC_W+1)'(1);

      if (ctl.drive) begin
         prev_in      = setpoint;
         frost_cnt_in = cnt;
         // a forced frost half-wave also restarts the cadence
         if (forced)
            restart_in = 1'b1;
         applied_in = mode_sel;
         wire_next  = lvl;
      end
      if (ctl.cut) begin
         if (applied_ff == MODE_OFF || applied_ff == MODE_FROST)
            wire_next = 1'b0;
      end
      if (ctl.tick) begin
         restart_in  = 1'b0;
         eco_in      = (c < ctl.eco_on);
         eco_plus_in = (c < ctl.eco_plus_on);
         sec_in      = (c_inc >= {1'b0, ctl.period}) ? '0 : c_inc[SEC_W-1:0];
      end
   end

   // Zone state
   always_ff @(posedge clock) begin
      if (reset) begin
         applied_ff   <= MODE_COMFORT;
         prev_ff      <= MODE_COMFORT;
         frost_cnt_ff <= '0;
         restart_ff   <= 1'b0;
         sec_ff       <= '0;
         eco_ff       <= 1'b0;
         eco_plus_ff  <= 1'b0;
      end else begin
         applied_ff   <= applied_in;
         prev_ff      <= prev_in;
         frost_cnt_ff <= frost_cnt_in;
         restart_ff   <= restart_in;
         sec_ff       <= sec_in;
         eco_ff       <= eco_in;
         eco_plus_ff  <= eco_plus_in;
      end
   end

endmodule

### hw/rtl/pilot_wire_heating_controller.sv
// Top level of the pilot-wire heating controller: event decode, zones, registers, result buffer.
// Takes one event per clock cycle while req_ready is high. Each accepted event updates the
// per-zone state and the wire levels at the acceptance edge; its result is registered into the
// output register, or the skid register while that stalls; the two entries keep req_ready high
// while one result waits, so events flow back to back; req_ready drops only when both are full.
// There is no clearing pass after reset. Registers are written over the APB-style csr_ port
// (byte address 4*index) and should be changed only while no event is in flight.
module pilot_wire_heating_controller
   import pwhc_pkg::*;
#(
   parameter int unsigned ZONE_COUNT = 4
)
(
   input  logic                  clock,
   input  logic                  reset,
   // event channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int unsigned ZONES_ACTIVE = (ZONE_COUNT < FIELD_ZONES) ? ZONE_COUNT : FIELD_ZONES;

   logic               hw_ver_ff;
   logic [FROST_W-1:0] frost_hw_ff;
   logic [SEC_W-1:0]   eco_on_ff, eco_plus_on_ff, period_ff;

   logic                   edge_armed_ff, edge_armed_in;
   logic                   mains_seen_ff, mains_seen_in;
   logic [FIELD_ZONES-1:0] wire_ff, wire_in;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;

   logic                   req_fire;
   logic                   csr_wr;
   logic [2:0]             csr_idx;
   zone_ctl_type           zctl;
   rsp_type                rsp_new;
   logic [FIELD_ZONES-1:0] wire_zone;
   logic [MODE_W-1:0]      sp [FIELD_ZONES];

   assign req_ready = !skid_valid_ff;
   assign req_fire  = req_valid && req_ready;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ver_ff      <= 1'b1;
         frost_hw_ff    <= FROST_W'(4);
         eco_on_ff      <= SEC_W'(3);
         eco_plus_on_ff <= SEC_W'(7);
         period_ff      <= SEC_W'(300);
      end else if (csr_wr) begin
         case (csr_idx)
            REG_HW_VERSION:  hw_ver_ff      <= csr_pwdata[0];
            REG_FROST_HALFW: frost_hw_ff    <= csr_pwdata[FROST_W-1:0];
            REG_ECO_ON:      eco_on_ff      <= csr_pwdata[SEC_W-1:0];
            REG_ECO_PLUS_ON: eco_plus_on_ff <= csr_pwdata[SEC_W-1:0];
            REG_CADENCE:     period_ff      <= csr_pwdata[SEC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_HW_VERSION:  csr_prdata = CSR_DATA_W'(hw_ver_ff);
         REG_FROST_HALFW: csr_prdata = CSR_DATA_W'(frost_hw_ff);
         REG_ECO_ON:      csr_prdata = CSR_DATA_W'(eco_on_ff);
         REG_ECO_PLUS_ON: csr_prdata = CSR_DATA_W'(eco_plus_on_ff);
         REG_CADENCE:     csr_prdata = CSR_DATA_W'(period_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // Event decode into zone controls
   always_comb begin
      zctl                 = '0;
      zctl.hw_direct       = hw_ver_ff;
      zctl.frost_halfwaves = frost_hw_ff;
      zctl.eco_on          = eco_on_ff;
      zctl.eco_plus_on     = eco_plus_on_ff;
      zctl.period          = period_ff;
      if (req_fire) begin
         case (req_data.operation)
            OP_MAINS_EDGE:  zctl.drive = edge_armed_ff;
            OP_HALF_PERIOD: begin
               zctl.drive    = mains_seen_ff;
               zctl.positive = 1'b1;
            end
            OP_TRIAC_CUT:   zctl.cut  = hw_ver_ff;
            OP_SECOND_TICK: zctl.tick = 1'b1;
            default: ;
         endcase
      end
   end

   assign sp[0] = req_data.setpoint_zone0;
   assign sp[1] = req_data.setpoint_zone1;
   assign sp[2] = req_data.setpoint_zone2;
   assign sp[3] = req_data.setpoint_zone3;

   // Zones
   for (genvar z = 0; z < FIELD_ZONES; z++) begin : g_zone
      if (z < ZONES_ACTIVE) begin : g_on
         pwhc_zone u_zone (
            .clock     (clock),
            .reset     (reset),
            .ctl       (zctl),
            .setpoint  (sp[z]),
            .wire_cur  (wire_ff[z]),
            .wire_next (wire_zone[z])
         );
      end else begin : g_off
         assign wire_zone[z] = 1'b0;
      end
   end

   // Mains tracking and wire state
   always_comb begin
      edge_armed_in          = edge_armed_ff;
      mains_seen_in          = mains_seen_ff;
      wire_in                = wire_ff;
      rsp_new                = '0;
      if (req_fire) begin
         wire_in = wire_zone;
         case (req_data.operation)
            OP_MAINS_EDGE: begin
               if (edge_armed_ff) begin
                  edge_armed_in = 1'b0;
                  mains_seen_in = 1'b1;
               end else begin
                  rsp_new.edge_ignored = 1'b1;
               end
            end
            OP_HALF_PERIOD: begin
               if (!mains_seen_ff) begin
                  wire_in            = '0;
                  rsp_new.mains_lost = 1'b1;
               end
               edge_armed_in = 1'b1;
               mains_seen_in = 1'b0;
            end
            default: ;
         endcase
      end
      rsp_new.wire_levels = wire_in;
   end

   // Result buffer: output register with skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = req_fire;
            skid_data_in  = rsp_new;
         end else begin
            out_valid_in = req_fire;
            out_data_in  = rsp_new;
         end
      end else if (req_fire) begin
         skid_valid_in = 1'b1;
         skid_data_in  = rsp_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_armed_ff <= 1'b1;
         mains_seen_ff <= 1'b0;
         wire_ff       <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         edge_armed_ff <= edge_armed_in;
         mains_seen_ff <= mains_seen_in;
         wire_ff       <= wire_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

### verif/pilot_wire_scoreboard_pkg.sv
// Scoreboard class for the pilot-wire heating controller: event predictor and result checker.
package pilot_wire_scoreboard_pkg;
   import pwhc_pkg::*;

   class pilot_wire_scoreboard;
      // register copy
      logic                     hw_direct;
      logic [FROST_W-1:0]       frost_halfwaves;
      logic [SEC_W-1:0]         eco_on_secs;
      logic [SEC_W-1:0]         eco_plus_on_secs;
      logic [SEC_W-1:0]         period_secs;
      // per-zone state
      logic [MODE_W-1:0]        applied [4];
      logic [MODE_W-1:0]        last_request [4];
      logic [FROST_W-1:0]       frost_left [4];
      logic                     restart_pending [4];
      logic [SEC_W-1:0]         secs [4];
      logic                     eco_on_now [4];
      logic                     eco_plus_on_now [4];
      // shared state
      logic                     mains_seen;
      logic                     edge_armed;
      logic [FIELD_ZONES-1:0]   wires;
      rsp_type                  expected_rsp [$];
      int unsigned              mismatches;

      function new();
         hw_direct        = 1'b1;
         frost_halfwaves  = 8'd4;
         eco_on_secs      = 9'd3;
         eco_plus_on_secs = 9'd7;
         period_secs      = 9'd300;
         for (int z = 0; z < 4; z++) begin
            applied[z]         = MODE_COMFORT;
            last_request[z]    = MODE_COMFORT;
            frost_left[z]      = '0;
            restart_pending[z] = 1'b0;
            secs[z]            = '0;
            eco_on_now[z]      = 1'b0;
            eco_plus_on_now[z] = 1'b0;
         end
         mains_seen = 1'b0;
         edge_armed = 1'b1;
         wires      = '0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_HW_VERSION:  hw_direct        = value[0];
            REG_FROST_HALFW: frost_halfwaves  = value[FROST_W-1:0];
            REG_ECO_ON:      eco_on_secs      = value[SEC_W-1:0];
            REG_ECO_PLUS_ON: eco_plus_on_secs = value[SEC_W-1:0];
            REG_CADENCE:     period_secs      = value[SEC_W-1:0];
            default: ;
         endcase
      endfunction

      // setpoint change tracking; returns the mode applied on this half-wave
      function logic [MODE_W-1:0] apply_request(int z, logic [MODE_W-1:0] req);
         logic [MODE_W-1:0] prev;
         logic [MODE_W-1:0] mode;
         logic              req_eco;
         logic              prev_eco;
         prev     = last_request[z];
         req_eco  = (req == MODE_ECO) || (req == MODE_ECO_PLUS);
         prev_eco = (prev == MODE_ECO) || (prev == MODE_ECO_PLUS);
         mode     = req;
         if (req != prev) begin
            if (req_eco) begin
               restart_pending[z] = 1'b1;
               if (prev_eco || prev == MODE_ECO_PLUS_PLUS)
                  frost_left[z] = frost_halfwaves;
            end
            if (req == MODE_COMFORT && prev_eco)
               frost_left[z] = frost_halfwaves;
            last_request[z] = req;
         end
         // forced frost counts down once per driven half-wave
         if (frost_left[z] != '0) begin
            frost_left[z]      = frost_left[z] - 8'd1;
            restart_pending[z] = 1'b1;
            mode               = MODE_FROST;
         end
         return mode;
      endfunction

      function logic level_of(int z, logic [MODE_W-1:0] mode, logic positive);
         logic s;
         case (mode)
            MODE_OFF:           s = positive;
            MODE_ECO:           s = eco_on_now[z];
            MODE_ECO_PLUS:      s = eco_plus_on_now[z];
            MODE_ECO_PLUS_PLUS: s = 1'b1;
            MODE_FROST:         s = !positive;
            default:            s = 1'b0;
         endcase
         return hw_direct ? s : !s;
      endfunction

      function void drive_wires(req_type ev, logic positive);
         logic [MODE_W-1:0]      requested [4];
         logic [MODE_W-1:0]      mode;
         logic [FIELD_ZONES-1:0] next_wires;
         requested[0] = ev.setpoint_zone0;
         requested[1] = ev.setpoint_zone1;
         requested[2] = ev.setpoint_zone2;
         requested[3] = ev.setpoint_zone3;
         next_wires   = '0;
         for (int z = 0; z < 4; z++) begin
            mode          = apply_request(z, requested[z]);
            applied[z]    = mode;
            next_wires[z] = level_of(z, mode, positive);
         end
         wires = next_wires;
      endfunction

      // predict the result of one accepted event transfer
      function void note_event(req_type ev);
         rsp_type    exp_rsp;
         logic       lost;
         logic       ignored;
         logic [9:0] count;
         lost    = 1'b0;
         ignored = 1'b0;
         case (ev.operation)
            OP_MAINS_EDGE: begin
               if (!edge_armed) begin
                  ignored = 1'b1;
               end else begin
                  edge_armed = 1'b0;
                  drive_wires(ev, 1'b0);
                  mains_seen = 1'b1;
               end
            end
            OP_HALF_PERIOD: begin
               if (mains_seen) begin
                  drive_wires(ev, 1'b1);
               end else begin
                  wires = '0;
                  lost  = 1'b1;
               end
               edge_armed = 1'b1;
               mains_seen = 1'b0;
            end
            OP_TRIAC_CUT: begin
               if (hw_direct) begin
                  for (int z = 0; z < 4; z++)
                     if (applied[z] == MODE_OFF || applied[z] == MODE_FROST)
                        wires[z] = 1'b0;
               end
            end
            default: begin
               // second tick: eco gates sampled from the counter, then it advances
               for (int z = 0; z < 4; z++) begin
                  if (restart_pending[z]) begin
                     restart_pending[z] = 1'b0;
                     secs[z]            = '0;
                  end
                  count              = {1'b0, secs[z]};
                  eco_on_now[z]      = count < eco_on_secs;
                  eco_plus_on_now[z] = count < eco_plus_on_secs;
                  count              = count + 10'd1;
                  if (count >= period_secs)
                     count = '0;
                  secs[z] = count[SEC_W-1:0];
               end
            end
         endcase
         exp_rsp.wire_levels  = wires;
         exp_rsp.mains_lost   = lost;
         exp_rsp.edge_ignored = ignored;
         expected_rsp.push_back(exp_rsp);
      endfunction

      // compare one accepted result transfer with the oldest prediction
      function void check_result(rsp_type got);
         rsp_type exp_rsp;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: wires %h lost %b ignored %b",
                        got.wire_levels, got.mains_lost, got.edge_ignored);
            return;
         end
         exp_rsp = expected_rsp.pop_front();
         if (got.wire_levels !== exp_rsp.wire_levels ||
             got.mains_lost !== exp_rsp.mains_lost ||
             got.edge_ignored !== exp_rsp.edge_ignored) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: wires exp %h got %h, lost exp %b got %b, ignored exp %b got %b",
                        exp_rsp.wire_levels, got.wire_levels, exp_rsp.mains_lost,
                        got.mains_lost, exp_rsp.edge_ignored, got.edge_ignored);
         end
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction
   endclass

endpackage

### verif/pilot_wire_heating_controller_tb.sv
// Testbench of the pilot-wire heating controller: directed and random events, checked per result.
module pilot_wire_heating_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pwhc_pkg::*;
   import pilot_wire_scoreboard_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned PHASE_EVENTS = 250;
   // setpoint codes with no defined meaning
   localparam logic [MODE_W-1:0] MODE_UNDEF_6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_UNDEF_7 = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   pilot_wire_scoreboard  sb;
   int unsigned           send_gap_pct = 17;
   int unsigned           recv_stall_pct = 80;
   int unsigned           events_sent = 0;
   int unsigned           cycle_count = 0;
   logic [MODE_W-1:0]     held_sp [4];

   pilot_wire_heating_controller u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: random stalls and checking of each transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_data);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // one event transfer; valid stays high after acceptance for the caller to decide
   task automatic send_event(logic [1:0] op, logic [MODE_W-1:0] s0, logic [MODE_W-1:0] s1,
                             logic [MODE_W-1:0] s2, logic [MODE_W-1:0] s3);
      req_type ev;
      ev.operation      = op;
      ev.setpoint_zone0 = s0;
      ev.setpoint_zone1 = s1;
      ev.setpoint_zone2 = s2;
      ev.setpoint_zone3 = s3;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      do @(posedge clock); while (!req_ready);
      sb.note_event(ev);
      events_sent++;
   endtask

   task automatic send_held(logic [1:0] op);
      send_event(op, held_sp[0], held_sp[1], held_sp[2], held_sp[3]);
   endtask

   // hold off the sender until every result is back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // APB write, back to back with the next one; caller closes the group
   task automatic csr_write(logic [2:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, value);
   endtask

   task automatic program_config(int unsigned hw, int unsigned frost, int unsigned eco,
                                 int unsigned eco_plus, int unsigned period);
      drain();
      csr_write(REG_HW_VERSION, hw);
      csr_write(REG_FROST_HALFW, frost);
      csr_write(REG_ECO_ON, eco);
      csr_write(REG_ECO_PLUS_ON, eco_plus);
      csr_write(REG_CADENCE, period);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [MODE_W-1:0] pick_setpoint();
      if ($urandom_range(99) < 6)
         return MODE_W'($urandom_range(7, 6));
      return MODE_W'($urandom_range(5));
   endfunction

   task automatic maybe_ticks();
      repeat ($urandom_range(2)) send_held(OP_SECOND_TICK);
   endtask

   // one mains period: edge (now and then left out), half-period timer, optional triac cuts and ticks
   task automatic send_mains_cycle();
      for (int z = 0; z < 4; z++)
         if ($urandom_range(99) < 12)
            held_sp[z] = pick_setpoint();
      // now and then the edge goes missing
      if ($urandom_range(9) != 0)
         send_held(OP_MAINS_EDGE);
      maybe_ticks();
      if ($urandom_range(1) == 1)
         send_held(OP_TRIAC_CUT);
      send_held(OP_HALF_PERIOD);
      if ($urandom_range(1) == 1)
         send_held(OP_TRIAC_CUT);
      maybe_ticks();
   endtask

   initial begin
      int unsigned phase_end;
      int unsigned phase_mid;
      bit          pressure_done;
      sb = new();
      for (int z = 0; z < 4; z++)
         held_sp[z] = MODE_COMFORT;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: timer without mains, ignored edge, cuts, forced frost, odd codes
      send_event(OP_HALF_PERIOD, MODE_COMFORT, MODE_COMFORT, MODE_COMFORT, MODE_COMFORT);
      send_event(OP_TRIAC_CUT, MODE_COMFORT, MODE_COMFORT, MODE_COMFORT, MODE_COMFORT);
      send_event(OP_MAINS_EDGE, MODE_OFF, MODE_COMFORT, MODE_ECO_PLUS_PLUS, MODE_FROST);
      send_event(OP_MAINS_EDGE, MODE_OFF, MODE_COMFORT, MODE_ECO_PLUS_PLUS, MODE_FROST);
      send_event(OP_TRIAC_CUT, MODE_OFF, MODE_COMFORT, MODE_ECO_PLUS_PLUS, MODE_FROST);
      send_event(OP_HALF_PERIOD, MODE_OFF, MODE_COMFORT, MODE_ECO_PLUS_PLUS, MODE_FROST);
      send_event(OP_TRIAC_CUT, MODE_OFF, MODE_COMFORT, MODE_ECO_PLUS_PLUS, MODE_FROST);
      send_event(OP_SECOND_TICK, MODE_OFF, MODE_COMFORT, MODE_ECO_PLUS_PLUS, MODE_FROST);
      send_event(OP_MAINS_EDGE, MODE_ECO, MODE_ECO_PLUS, MODE_UNDEF_6, MODE_UNDEF_7);
      send_event(OP_SECOND_TICK, MODE_ECO, MODE_ECO_PLUS, MODE_UNDEF_6, MODE_UNDEF_7);
      send_event(OP_HALF_PERIOD, MODE_ECO, MODE_ECO_PLUS, MODE_UNDEF_6, MODE_UNDEF_7);
      // eco to eco plus and back forces frost
      send_event(OP_MAINS_EDGE, MODE_ECO_PLUS, MODE_ECO, MODE_ECO_PLUS_PLUS, MODE_ECO_PLUS_PLUS);
      send_event(OP_HALF_PERIOD, MODE_ECO_PLUS, MODE_ECO, MODE_ECO_PLUS_PLUS, MODE_ECO_PLUS_PLUS);
      send_event(OP_MAINS_EDGE, MODE_ECO_PLUS, MODE_ECO, MODE_ECO_PLUS_PLUS, MODE_ECO_PLUS_PLUS);
      send_event(OP_HALF_PERIOD, MODE_ECO_PLUS, MODE_ECO, MODE_ECO_PLUS_PLUS, MODE_ECO_PLUS_PLUS);
      send_event(OP_SECOND_TICK, MODE_ECO_PLUS, MODE_ECO, MODE_ECO_PLUS_PLUS, MODE_ECO_PLUS_PLUS);
      // comfort after eco, eco after eco plus plus
      send_event(OP_MAINS_EDGE, MODE_COMFORT, MODE_COMFORT, MODE_ECO, MODE_OFF);
      send_event(OP_HALF_PERIOD, MODE_COMFORT, MODE_COMFORT, MODE_ECO, MODE_OFF);
      send_event(OP_MAINS_EDGE, MODE_UNDEF_7, MODE_UNDEF_7, MODE_UNDEF_7, MODE_UNDEF_7);
      send_event(OP_HALF_PERIOD, MODE_OFF, MODE_OFF, MODE_OFF, MODE_OFF);
      // old hardware: inverted levels, no triac cut
      program_config(0, 4, 3, 7, 300);
      send_event(OP_MAINS_EDGE, MODE_OFF, MODE_COMFORT, MODE_ECO_PLUS, MODE_FROST);
      send_event(OP_TRIAC_CUT, MODE_OFF, MODE_COMFORT, MODE_ECO_PLUS, MODE_FROST);
      send_event(OP_HALF_PERIOD, MODE_OFF, MODE_COMFORT, MODE_ECO_PLUS, MODE_FROST);
      send_event(OP_SECOND_TICK, MODE_OFF, MODE_COMFORT, MODE_ECO_PLUS, MODE_FROST);
      send_event(OP_MAINS_EDGE, MODE_OFF, MODE_COMFORT, MODE_ECO_PLUS, MODE_FROST);

      // random phases, each under its own register setting
      for (int p = 0; p < 6; p++) begin
         if (p >= 4) begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
         end else if (p >= 2) begin
            send_gap_pct   = 80;
            recv_stall_pct = 17;
         end
         case (p)
            0: program_config(1, 3, 2, 5, 8);
            1: program_config(0, 0, 0, 511, 1);
            2: program_config(1, 255, 511, 0, 511);
            3: program_config(0, 1, 4, 9, 0);
            4: program_config(1, 2, 6, 3, 12);
            default: program_config($urandom_range(1), $urandom_range(8), $urandom_range(20),
                                    $urandom_range(20), $urandom_range(25, 1));
         endcase
         phase_end     = events_sent + PHASE_EVENTS;
         phase_mid     = events_sent + PHASE_EVENTS / 2;
         pressure_done = 1'b0;
         while (events_sent < phase_end) begin
            if (!pressure_done && events_sent >= phase_mid) begin
               drain();
               pressure_done = 1'b1;
            end
            // mostly well-formed mains periods, some arbitrary events
            if ($urandom_range(99) < 15)
               send_event(2'($urandom_range(3)), MODE_W'($urandom_range(7)),
                          MODE_W'($urandom_range(7)), MODE_W'($urandom_range(7)),
                          MODE_W'($urandom_range(7)));
            else
               send_mains_cycle();
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (sb.mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
